@@ hw/rtl/ccfp_pkg.sv @@
package ccfp_pkg;

    // Request kinds carried in s_tuser.
    typedef enum logic [1:0] {
        REQ_PUT  = 2'd0,
        REQ_RX   = 2'd1,
        REQ_POP  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // Configuration register indexes (byte address is 4 times the index).
    localparam logic [1:0] REG_UNIT_CAN_ID     = 2'd0;
    localparam logic [1:0] REG_DATA_CMD_CODE   = 2'd1;
    localparam logic [1:0] REG_SWITCH_CMD_CODE = 2'd2;

    localparam logic [7:0] SWITCH_ON = 8'hA5;
    localparam logic [7:0] NEWLINE   = 8'h0A;
    localparam logic [2:0] MAX_CHARS = 3'd7;

    localparam int RING_DEPTH_DEF = 32;

    localparam int CHARS_W = 56;
    localparam int LEN_W   = 4;
    localparam int ENTRY_W = CHARS_W + LEN_W;

    typedef struct packed {
        logic [31:0] unit_can_id;
        logic [7:0]  data_cmd_code;
        logic [7:0]  switch_cmd_code;
    } cfg_t;

    // A frame closed by the assembler, offered to the ring.
    typedef struct packed {
        logic               close;
        logic [LEN_W-1:0]   len;
        logic [CHARS_W-1:0] chars;
    } close_req_t;

    typedef struct packed {
        logic hit;
        logic ovf;
    } ring_stat_t;

    typedef struct packed {
        logic frame_valid;
        logic char_taken;
        logic overflow;
    } res_meta_t;

endpackage

@@ hw/rtl/ccfp_cfg.sv @@
module ccfp_cfg
    import ccfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_UNIT_CAN_ID:     cfg_reg.unit_can_id     <= pwdata;
                REG_DATA_CMD_CODE:   cfg_reg.data_cmd_code   <= pwdata[7:0];
                REG_SWITCH_CMD_CODE: cfg_reg.switch_cmd_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_UNIT_CAN_ID:     prdata = cfg_reg.unit_can_id;
            REG_DATA_CMD_CODE:   prdata = {24'd0, cfg_reg.data_cmd_code};
            REG_SWITCH_CMD_CODE: prdata = {24'd0, cfg_reg.switch_cmd_code};
            default:             prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/ccfp_asm.sv @@
module ccfp_asm
    import ccfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  req_t        req,
    input  logic [7:0]  char_in,
    input  logic [31:0] rx_id,
    input  logic [7:0]  rx_first_byte,
    input  logic [7:0]  rx_second_byte,
    input  cfg_t        cfg,
    output close_req_t  close_req,
    output logic        char_taken
);

    logic [7:0]         switch_reg, switch_next;
    logic [CHARS_W-1:0] chars_reg, chars_next;
    logic [2:0]         count_reg, count_next;

    always_comb begin
        logic [CHARS_W-1:0] filled;
        logic [2:0]         count_inc;
        logic               put_ok;
        logic               close;

        put_ok    = accept && (req == REQ_PUT) && (switch_reg == SWITCH_ON);
        count_inc = count_reg + 3'd1;
        filled    = chars_reg;
        for (int b = 0; b < 7; b++) begin
            if (count_reg == 3'(b)) begin
                filled[b*8 +: 8] = char_in;
            end
        end
        close = put_ok && ((char_in == NEWLINE) || (count_inc == MAX_CHARS));

        switch_next = switch_reg;
        if (accept && (req == REQ_RX) && (rx_id == cfg.unit_can_id)
            && (rx_first_byte == cfg.switch_cmd_code)) begin
            switch_next = rx_second_byte;
        end

        chars_next = chars_reg;
        count_next = count_reg;
        if (close) begin
            chars_next = '0;
            count_next = '0;
        end else if (put_ok) begin
            chars_next = filled;
            count_next = count_inc;
        end

        // The length code counts the command byte as well.
        close_req.close = close;
        close_req.len   = {1'b0, count_inc} + 4'd1;
        close_req.chars = filled;
        char_taken      = put_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_reg <= '0;
            chars_reg  <= '0;
            count_reg  <= '0;
        end else begin
            switch_reg <= switch_next;
            chars_reg  <= chars_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/ccfp_ring.sv @@
module ccfp_ring
    import ccfp_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_req,
    input  close_req_t         close_req,
    output ring_stat_t         stat,
    output logic [ENTRY_W-1:0] rdata
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

    logic [ENTRY_W-1:0] mem [RING_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [PTR_W-1:0]   wr_reg, wr_next, wr_inc;
    logic [PTR_W-1:0]   rd_reg, rd_next, rd_inc;
    logic               full, empty, push_do, pop_do;

    assign wr_inc  = (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
    assign rd_inc  = (rd_reg == LAST_SLOT) ? '0 : rd_reg + 1'b1;
    // One slot stays unused so that full and empty differ.
    assign full    = (wr_inc == rd_reg);
    assign empty   = (wr_reg == rd_reg);
    assign push_do = close_req.close && !full;
    assign pop_do  = pop_req && !empty;
    assign wr_next = push_do ? wr_inc : wr_reg;
    assign rd_next = pop_do ? rd_inc : rd_reg;

    assign stat.hit = pop_do;
    assign stat.ovf = close_req.close && full;
    assign rdata    = rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_do) begin
            mem[wr_reg] <= {close_req.len, close_req.chars};
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_do) begin
            rdata_reg <= mem[rd_reg];
        end
    end

endmodule

@@ hw/rtl/ccfp_out.sv @@
module ccfp_out
    import ccfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  res_meta_t          meta,
    input  logic [ENTRY_W-1:0] rdata,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,
    output logic [0:0]         m_tuser
);

    logic               p_valid_reg, p_valid_next;
    res_meta_t          p_meta_reg;
    logic               o_valid_reg, o_valid_next;
    logic [63:0]        o_data_reg, o_data_next;
    logic               o_frame_reg, o_frame_next;
    logic               p_move;

    assign p_move   = !o_valid_reg || m_tready;
    assign s_tready = !p_valid_reg || p_move;

    always_comb begin
        logic [LEN_W-1:0]   len;
        logic [CHARS_W-1:0] chars;

        len   = p_meta_reg.frame_valid ? rdata[ENTRY_W-1 -: LEN_W] : '0;
        chars = p_meta_reg.frame_valid ? rdata[CHARS_W-1:0] : '0;

        p_valid_next = p_move ? accept : (p_valid_reg || accept);
        o_valid_next = p_move ? p_valid_reg : o_valid_reg;
        o_data_next  = o_data_reg;
        o_frame_next = o_frame_reg;
        if (p_move && p_valid_reg) begin
            o_data_next  = {2'b00, p_meta_reg.overflow, p_meta_reg.char_taken, chars, len};
            o_frame_next = p_meta_reg.frame_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_meta_reg <= meta;
        end
        o_data_reg  <= o_data_next;
        o_frame_reg <= o_frame_next;
    end

    assign m_tvalid   = o_valid_reg;
    assign m_tdata    = o_data_reg;
    assign m_tuser[0] = o_frame_reg;

endmodule

@@ hw/rtl/char_to_can_frame_packer.sv @@
// Channel  | Direction | Handshake          | Contents
// s_       | in        | s_tvalid/s_tready  | requests: put character, CAN message, pop
// m_       | out       | m_tvalid/m_tready  | one result word for every request
// APB      | in        | psel/penable       | unit_can_id, data_cmd_code, switch_cmd_code
//
// One request word is accepted per cycle while s_tready is high. Its result is registered
// first in the frame ring's read port and the pipeline stage, then in the output register.
// Reset (aresetn, synchronous, active low) clears pointers, assembly and switch.
// The ring memory needs no clearing pass, since only written slots are read.
// A stall on m_tready fills the output register and then the pipeline stage.
// Only after both are full does it drop s_tready.
module char_to_can_frame_packer
    import ccfp_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_in [7:0], rx_id [39:8], rx_first_byte [47:40], rx_second_byte [55:48]
    input  logic [55:0] s_tdata,
    // req_type [1:0]
    input  logic [1:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_length [3:0], frame_chars [59:4], char_taken [60], overflow [61], zero [63:62]
    output logic [63:0] m_tdata,
    // frame_valid [0]
    output logic [0:0]  m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t               cfg;
    req_t               req;
    logic               accept;
    close_req_t         close_req;
    logic               char_taken;
    ring_stat_t         ring_stat;
    logic [ENTRY_W-1:0] ring_rdata;
    res_meta_t          meta;

    // A word enters the block when both sides of the request handshake agree.
    assign accept = s_tvalid && s_tready;
    assign req    = req_t'(s_tuser);

    ccfp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The assembler holds the switch byte and the partly filled frame. It
    // closes a frame on a newline or on the seventh character.
    ccfp_asm u_asm (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .req            (req),
        .char_in        (s_tdata[7:0]),
        .rx_id          (s_tdata[39:8]),
        .rx_first_byte  (s_tdata[47:40]),
        .rx_second_byte (s_tdata[55:48]),
        .cfg            (cfg),
        .close_req      (close_req),
        .char_taken     (char_taken)
    );

    // The ring stores closed frames. A frame that closes while the ring is
    // full is dropped, and the result word flags the overflow.
    ccfp_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_req   (accept && (req == REQ_POP)),
        .close_req (close_req),
        .stat      (ring_stat),
        .rdata     (ring_rdata)
    );

    assign meta.frame_valid = ring_stat.hit;
    assign meta.char_taken  = char_taken;
    assign meta.overflow    = ring_stat.ovf;

    // The flags are registered next to the ring read data. Then the result
    // word is built and registered.
    ccfp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .meta     (meta),
        .rdata    (ring_rdata),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ hw/rtl/ccfp_checker.sv @@
module ccfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A result waiting for the sink stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word offered right after reset");

    // A word without a frame carries no length and no characters.
    a_no_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[59:0] == 60'd0))
        else $error("frame fields set without a frame");

    // A popped frame holds at least one character plus the command byte.
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[3:0] >= 4'd2) && (m_tdata[3:0] <= 4'd8))
        else $error("popped frame length out of range");

    // A pop never takes a character or drops a frame.
    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tdata[60] && !m_tdata[61])
        else $error("pop result also reports a put");

endmodule

bind char_to_can_frame_packer ccfp_checker u_ccfp_checker (.*);
